/* rtl/kmpt_pkg.sv */
// Shared constants, codes and control types of the keyed max-priority table.
package kmpt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 64;
    localparam int RATIO_W  = 7;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = KEY_W + RATIO_W;

    localparam int IN_W     = ((CMD_W + KEY_W + RATIO_W + 7) / 8) * 8;
    localparam int OUT_W    = ((STATUS_W + KEY_W + RATIO_W + 7) / 8) * 8;

    localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(100);

    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             commit;
    } kmpt_ctrl_t;

    typedef struct packed {
        logic out_free;
    } kmpt_stat_t;

endpackage

/* rtl/keyed_max_priority_table.sv */
// Top level of the keyed max-priority table: controller plus datapath.
//
//  channel  dir  fields (tdata, lowest bit up)                      transaction
//  s_axis   in   cmd[1:0] key[65:2] ratio[72:66] zero[79:73]        s_tvalid & s_tready
//  m_axis   out  status[1:0] popped_key[65:2] popped_ratio[72:66]   m_tvalid & m_tready
//
//  Clear goes from accept straight to the commit state; update, remove and
//  pop first sweep all CAPACITY entries, reading one table entry per cycle
//  through the single read port of the entry RAM, then drain and commit.
//  rst_n clears the valid marks and all control state at once; key and ratio
//  storage is not cleared, and an entry is only looked at while it is valid.
//  A result waits in the output register while m_tready is low; the next
//  transaction is still accepted and swept, and holds only at commit.
module keyed_max_priority_table (
    input  logic                        clk,
    input  logic                        rst_n,
    // slave side: cmd[1:0], key[65:2], ratio[72:66], zero fill above
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [kmpt_pkg::IN_W-1:0]   s_tdata,
    // master side: status[1:0], popped_key[65:2], popped_ratio[72:66], zero fill
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [kmpt_pkg::OUT_W-1:0]  m_tdata
);
    import kmpt_pkg::*;

    kmpt_ctrl_t          ctrl;
    kmpt_stat_t          stat;
    logic [CMD_W-1:0]    in_cmd;
    logic [KEY_W-1:0]    in_key;
    logic [RATIO_W-1:0]  in_ratio;
    logic [STATUS_W-1:0] out_status;
    logic [KEY_W-1:0]    out_key;
    logic [RATIO_W-1:0]  out_ratio;

    // Unpack the command transaction.
    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_key   = s_tdata[CMD_W+KEY_W-1:CMD_W];
    assign in_ratio = s_tdata[CMD_W+KEY_W+RATIO_W-1:CMD_W+KEY_W];

    kmpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (in_cmd),
        .in_ready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    kmpt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_cmd     (in_cmd),
        .in_key     (in_key),
        .in_ratio   (in_ratio),
        .ctrl       (ctrl),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_key    (out_key),
        .out_ratio  (out_ratio)
    );

    // Pack the result transaction, zero fill to whole bytes.
    assign m_tdata = {(OUT_W - STATUS_W - KEY_W - RATIO_W)'(0), out_ratio, out_key,
                      out_status};

endmodule

/* rtl/kmpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kmpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/kmpt_ctrl.sv */
// Command sequencer: accept a transaction, sweep the table, commit the result.
module kmpt_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [kmpt_pkg::CMD_W-1:0]    in_cmd,
    output logic                          in_ready,
    input  kmpt_pkg::kmpt_stat_t          stat,
    output kmpt_pkg::kmpt_ctrl_t          ctrl
);
    import kmpt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             last;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign last     = (cnt_reg == IDX_W'(CAPACITY - 1));

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ctrl.load    = 1'b0;
        ctrl.rd_en   = 1'b0;
        ctrl.rd_addr = cnt_reg;
        ctrl.commit  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    ctrl.load  = 1'b1;
                    state_next = (in_cmd == CMD_CLEAR) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.rd_en = 1'b1;
                if (last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/kmpt_dp.sv */
// Datapath: command latch, entry store, sweep compare and result register.
module kmpt_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [kmpt_pkg::CMD_W-1:0]      in_cmd,
    input  logic [kmpt_pkg::KEY_W-1:0]      in_key,
    input  logic [kmpt_pkg::RATIO_W-1:0]    in_ratio,
    input  kmpt_pkg::kmpt_ctrl_t            ctrl,
    output kmpt_pkg::kmpt_stat_t            stat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [kmpt_pkg::STATUS_W-1:0]   out_status,
    output logic [kmpt_pkg::KEY_W-1:0]      out_key,
    output logic [kmpt_pkg::RATIO_W-1:0]    out_ratio
);
    import kmpt_pkg::*;

    // latched command
    logic [CMD_W-1:0]    op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [RATIO_W-1:0]  ratio_reg;

    // sweep compare stage
    logic                cmp_v_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic [ENTRY_W-1:0]  rd_data;
    logic [KEY_W-1:0]    rd_key;
    logic [RATIO_W-1:0]  rd_ratio;
    logic                rd_live;
    logic                better;

    logic                hit_reg, free_reg, best_reg;
    logic [IDX_W-1:0]    hit_idx_reg, free_idx_reg, best_idx_reg;
    logic [KEY_W-1:0]    best_key_reg;
    logic [RATIO_W-1:0]  best_ratio_reg;

    logic [CAPACITY-1:0] valid_reg, valid_next;

    // commit decisions
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [STATUS_W-1:0] res_status;
    logic [KEY_W-1:0]    res_key;
    logic [RATIO_W-1:0]  res_ratio;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [KEY_W-1:0]    out_key_reg;
    logic [RATIO_W-1:0]  out_ratio_reg;

    kmpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata ({key_reg, ratio_reg}),
        .re    (ctrl.rd_en),
        .raddr (ctrl.rd_addr),
        .rdata (rd_data)
    );

    assign rd_key   = rd_data[ENTRY_W-1:RATIO_W];
    assign rd_ratio = rd_data[RATIO_W-1:0];
    assign rd_live  = cmp_v_reg && valid_reg[cmp_idx_reg];
    assign better   = !best_reg || (rd_ratio > best_ratio_reg) ||
                      ((rd_ratio == best_ratio_reg) && (rd_key > best_key_reg));

    // Latch the command, saturating the ratio at RATIO_MAX; an update with ratio zero runs as a remove.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            key_reg   <= in_key;
            ratio_reg <= (in_ratio > RATIO_MAX) ? RATIO_MAX : in_ratio;
            if ((in_cmd == CMD_UPDATE) && (in_ratio == '0))
            begin
                op_reg <= CMD_REMOVE;
            end
            else
            begin
                op_reg <= in_cmd;
            end
        end
    end

    // Sweep result trackers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_v_reg <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            best_reg  <= 1'b0;
        end
        else
        begin
            cmp_v_reg <= ctrl.rd_en;
            if (ctrl.load)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
                best_reg <= 1'b0;
            end
            else if (cmp_v_reg)
            begin
                if (rd_live && (rd_key == key_reg))
                begin
                    hit_reg <= 1'b1;
                end
                if (!free_reg && !valid_reg[cmp_idx_reg])
                begin
                    free_reg <= 1'b1;
                end
                if (rd_live && better)
                begin
                    best_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= ctrl.rd_addr;
        if (cmp_v_reg)
        begin
            if (rd_live && (rd_key == key_reg))
            begin
                hit_idx_reg <= cmp_idx_reg;
            end
            if (!free_reg && !valid_reg[cmp_idx_reg])
            begin
                free_idx_reg <= cmp_idx_reg;
            end
            if (rd_live && better)
            begin
                best_idx_reg   <= cmp_idx_reg;
                best_key_reg   <= rd_key;
                best_ratio_reg <= rd_ratio;
            end
        end
    end

    // Decide the write, the valid change and the result of the command.
    always_comb
    begin
        valid_next = valid_reg;
        we         = 1'b0;
        waddr      = hit_idx_reg;
        res_status = ST_OK;
        res_key    = '0;
        res_ratio  = '0;
        case (op_reg)
            CMD_UPDATE:
            begin
                if (hit_reg)
                begin
                    we = ctrl.commit;
                end
                else if (free_reg)
                begin
                    we    = ctrl.commit;
                    waddr = free_idx_reg;
                    valid_next[free_idx_reg] = 1'b1;
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            CMD_REMOVE:
            begin
                if (hit_reg)
                begin
                    valid_next[hit_idx_reg] = 1'b0;
                end
                else
                begin
                    res_status = ST_NOT_FOUND;
                end
            end
            CMD_POP:
            begin
                if (best_reg)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                    res_key   = best_key_reg;
                    res_ratio = best_ratio_reg;
                end
                else
                begin
                    res_status = ST_EMPTY;
                end
            end
            default:
            begin
                valid_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.commit)
            begin
                valid_reg     <= valid_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_status_reg <= res_status;
            out_key_reg    <= res_key;
            out_ratio_reg  <= res_ratio;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_key       = out_key_reg;
    assign out_ratio     = out_ratio_reg;

endmodule

/* rtl/kmpt_checker.sv */
// Port-level checks of the keyed max-priority table and their binding.
module kmpt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [kmpt_pkg::OUT_W-1:0]  m_tdata
);
    import kmpt_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // One command at a time: ready drops after a transaction is accepted.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command taken during processing");

    // A failed command carries zero popped fields.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[STATUS_W-1:0] != ST_OK)) |->
        (m_tdata[STATUS_W+KEY_W+RATIO_W-1:STATUS_W] == '0))
        else $error("popped fields nonzero on failed command");

    // Popped ratios never exceed the saturation limit.
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
        (m_tdata[STATUS_W+KEY_W+RATIO_W-1:STATUS_W+KEY_W] <= RATIO_MAX))
        else $error("popped ratio above limit");

endmodule

bind keyed_max_priority_table kmpt_checker u_kmpt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* dv/testbench.sv */
// Self-checking testbench for the keyed max-priority table: stream stimulus and table scoreboard.
`timescale 1ns / 100ps

import kmpt_pkg::*;

// One response as the master side carries it.
typedef struct {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    popped_key;
    logic [RATIO_W-1:0]  popped_ratio;
} table_result_t;

// Shadow copy of the entry table; turns each accepted command into the
// response it must produce and checks responses in order.
class table_scoreboard;
    bit                  used   [CAPACITY];
    bit [KEY_W-1:0]      keys   [CAPACITY];
    bit [RATIO_W-1:0]    ratios [CAPACITY];
    table_result_t       pending [$];
    int                  errors;

    function new();
        foreach (used[i])
        begin
            used[i] = 1'b0;
        end
        errors = 0;
    endfunction

    function int find_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (used[i] && keys[i] == key)
                return i;
        end
        return -1;
    endfunction

    function logic [STATUS_W-1:0] remove_key(logic [KEY_W-1:0] key);
        int idx;
        idx = find_key(key);
        if (idx < 0)
            return ST_NOT_FOUND;
        used[idx] = 1'b0;
        return ST_OK;
    endfunction

    function table_result_t apply_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                          logic [RATIO_W-1:0] ratio);
        table_result_t      res;
        logic [RATIO_W-1:0] clipped;
        int                 idx;
        int                 best;
        res.status       = ST_OK;
        res.popped_key   = '0;
        res.popped_ratio = '0;
        case (cmd)
            CMD_UPDATE:
            begin
                if (ratio == '0)
                    res.status = remove_key(key);
                else
                begin
                    clipped = (ratio > RATIO_MAX) ? RATIO_MAX : ratio;
                    idx = find_key(key);
                    if (idx >= 0)
                        ratios[idx] = clipped;
                    else
                    begin
                        // insert into the lowest free entry
                        idx = -1;
                        for (int i = 0; i < CAPACITY && idx < 0; i++)
                        begin
                            if (!used[i])
                                idx = i;
                        end
                        if (idx < 0)
                            res.status = ST_FULL;
                        else
                        begin
                            used[idx]   = 1'b1;
                            keys[idx]   = key;
                            ratios[idx] = clipped;
                        end
                    end
                end
            end
            CMD_REMOVE:
                res.status = remove_key(key);
            CMD_POP:
            begin
                best = -1;
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (used[i] && (best < 0 || ratios[i] > ratios[best] ||
                        (ratios[i] == ratios[best] && keys[i] > keys[best])))
                        best = i;
                end
                if (best < 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.popped_key   = keys[best];
                    res.popped_ratio = ratios[best];
                    used[best]       = 1'b0;
                end
            end
            default:
            begin
                foreach (used[i])
                begin
                    used[i] = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                               logic [RATIO_W-1:0] ratio);
        pending.push_back(apply_command(cmd, key, ratio));
    endfunction

    function void report(string what, logic [KEY_W-1:0] expected, logic [KEY_W-1:0] actual);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, expected,
                 actual);
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
        table_result_t want;
        if (pending.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %0h", $time, word);
            return;
        end
        want = pending.pop_front();
        if (word[1:0] !== want.status)
            report("status", KEY_W'(want.status), KEY_W'(word[1:0]));
        if (word[65:2] !== want.popped_key)
            report("popped_key", want.popped_key, word[65:2]);
        if (word[72:66] !== want.popped_ratio)
            report("popped_ratio", KEY_W'(want.popped_ratio), KEY_W'(word[72:66]));
    endfunction

    function int outstanding();
        return pending.size();
    endfunction
endclass

module testbench;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1900;
    localparam int POOL_SIZE    = 96;
    // longest sweep covers all CAPACITY entries; leave room behind it
    localparam int SETTLE       = CAPACITY + 16;
    localparam int CYCLE_LIMIT  = 1000000;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;

    table_scoreboard    board;
    logic [KEY_W-1:0]   key_pool [POOL_SIZE];
    // when set, neither side inserts idle cycles
    bit                 calm_phase = 1'b0;
    int                 commands_sent = 0;
    int                 cycle_count = 0;

    keyed_max_priority_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Hold the command on the slave side until the transaction completes,
    // then hand it to the scoreboard. Leave tvalid high when the next
    // command follows with no gap.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                logic [RATIO_W-1:0] ratio);
        int gap;
        gap = calm_phase ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({ratio, key, cmd});
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        board.note_command(cmd, key, ratio);
        commands_sent++;
    endtask

    // Drop tvalid and wait until every response has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.outstanding() != 0);
    endtask

    // Mostly keys from the shared pool so updates and removes hit stored entries.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    // Zero, saturating values, a narrow band that forces ratio ties and the range 1 to 100.
    function automatic logic [RATIO_W-1:0] pick_ratio();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return RATIO_W'($urandom_range(101, 127));
        if (sel < 5)
            return RATIO_W'($urandom_range(1, 3));
        return RATIO_W'($urandom_range(1, 100));
    endfunction

    // Receiver: draw a stall per response, then take one transaction and check it.
    initial
    begin
        int stall;
        forever
        begin
            stall = calm_phase ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            board.check_result(m_tdata);
        end
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int kind;
        int count;
        int sel;
        int random_start;
        board = new();
        key_pool[0] = '0;
        key_pool[1] = '1;
        // half the pool shares the upper word so ties are broken on low bits
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = (i % 2) ? {32'hA5A5_5A5A, $urandom} : {$urandom, $urandom};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pop, absent keys, key extremes, saturation, ties,
        // same-ratio update, ratio-zero removal, clear, ignored keys.
        calm_phase <= 1'b0;
        send_command(CMD_POP, '1, 7'd127);
        send_command(CMD_REMOVE, 64'h1234_5678_9ABC_DEF0, '0);
        send_command(CMD_UPDATE, 64'h1234_5678_9ABC_DEF0, '0);
        send_command(CMD_UPDATE, '0, 7'd1);
        send_command(CMD_UPDATE, '1, RATIO_MAX);
        send_command(CMD_UPDATE, 64'h5555_5555_5555_5555, 7'd127);
        send_command(CMD_UPDATE, '0, 7'd1);
        send_command(CMD_UPDATE, '0, RATIO_MAX);
        send_command(CMD_UPDATE, 64'hAAAA_AAAA_AAAA_AAAA, 7'd101);
        send_command(CMD_POP, '0, '0);
        send_command(CMD_POP, 64'h5555_5555_5555_5555, 7'd50);
        send_command(CMD_UPDATE, 64'h5555_5555_5555_5555, '0);
        send_command(CMD_REMOVE, '0, 7'd3);
        send_command(CMD_REMOVE, '0, 7'd3);
        send_command(CMD_UPDATE, 64'h8000_0000_0000_0000, 7'd64);
        send_command(CMD_UPDATE, 64'h0000_0000_0000_0001, 7'd64);
        send_command(CMD_UPDATE, 64'h7FFF_FFFF_FFFF_FFFF, 7'd64);
        send_command(CMD_POP, '1, 7'd127);
        send_command(CMD_CLEAR, 64'hDEAD_BEEF_0BAD_F00D, 7'd99);
        send_command(CMD_POP, '0, '0);
        send_command(CMD_REMOVE, 64'h0000_0000_0000_0001, 7'd1);
        // hold off the sender until every response is in
        drain_results();

        random_start = commands_sent;
        while (commands_sent - random_start < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 3);
            calm_phase <= ($urandom_range(0, 3) == 0);
            case (kind)
                0:
                begin
                    // clear, overfill with fresh keys, then pop past empty
                    send_command(CMD_CLEAR, pick_key(), pick_ratio());
                    count = CAPACITY + $urandom_range(2, 8);
                    for (int i = 0; i < count; i++)
                        send_command(CMD_UPDATE, {$urandom, $urandom},
                                     RATIO_W'($urandom_range(1, 127)));
                    for (int i = 0; i < CAPACITY + 2; i++)
                        send_command(CMD_POP, pick_key(), pick_ratio());
                end
                1:
                begin
                    // insert-heavy mix over the pool
                    for (int i = 0; i < 100; i++)
                    begin
                        sel = $urandom_range(0, 99);
                        if (sel < 60)
                            send_command(CMD_UPDATE, pick_key(), pick_ratio());
                        else if (sel < 80)
                            send_command(CMD_REMOVE, pick_key(), pick_ratio());
                        else if (sel < 97)
                            send_command(CMD_POP, pick_key(), pick_ratio());
                        else
                            send_command(CMD_CLEAR, pick_key(), pick_ratio());
                    end
                end
                2:
                begin
                    // drain-heavy mix
                    for (int i = 0; i < 60; i++)
                    begin
                        sel = $urandom_range(0, 99);
                        if (sel < 25)
                            send_command(CMD_UPDATE, pick_key(), pick_ratio());
                        else if (sel < 40)
                            send_command(CMD_REMOVE, pick_key(), pick_ratio());
                        else
                            send_command(CMD_POP, pick_key(), pick_ratio());
                    end
                end
                default:
                begin
                    // raw noise over every field value
                    for (int i = 0; i < 40; i++)
                        send_command(CMD_W'($urandom_range(0, 3)),
                                     ($urandom_range(0, 1) != 0) ? {$urandom, $urandom}
                                                                 : pick_key(),
                                     RATIO_W'($urandom_range(0, 127)));
                end
            endcase
            if ($urandom_range(0, 1) != 0)
                drain_results();
        end

        // wait out the last responses, then watch for strays
        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
